// ----- sv/sbi_pkg.sv -----
// ----------------------------------------------------------------------------
// sbi_pkg
// Shared types for the segment versus box intersection block.
// ----------------------------------------------------------------------------
package sbi_pkg;

  // Per-axis verdict handed from the axis stage to the result stage.
  typedef struct packed {
    logic active;  // the segment moves along this axis
    logic ok;      // every test local to this axis passes
  } axis_flags_t;

  // Result latency in clock edges from the accepting edge to the strobe edge.
  localparam int unsigned ResultLatency = 2;

endpackage

// ----- sv/segment_box_intersect_2d.sv -----
// ----------------------------------------------------------------------------
// segment_box_intersect_2d
// Exact 2D slab test of a line segment against a closed axis-aligned box.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                   Direction  Handshake
//   --------  ----------------------------------------  ---------  ------------------
//   command   start, start_x_i .. box_max_y_i           in         start && !busy
//   result    done_o, hit_o                             out        done_o, one cycle
//
// A command beat is accepted on every rising edge where start is high; busy
// never rises, so a new segment can enter in every cycle. The accepting edge
// loads the per-axis fractions into the input register, the result register
// then loads the verdict from the cross-multiplier compare, and done_o marks it
// for exactly one cycle. The receiver cannot stall, so no beat is ever held.
// Reset is asynchronous and active low; it clears the valid pipeline only.
//
// Every fraction is kept as a signed numerator over a positive denominator,
// and the two cross-axis comparisons use four parallel multipliers of
// (COORD_BITS+1) x (COORD_BITS+1) bits, so no rounding takes place.
// ----------------------------------------------------------------------------
module segment_box_intersect_2d #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [COORD_BITS-1:0] box_min_x_i,
  input  logic signed [COORD_BITS-1:0] box_min_y_i,
  input  logic signed [COORD_BITS-1:0] box_max_x_i,
  input  logic signed [COORD_BITS-1:0] box_max_y_i,
  output logic                         done_o,
  output logic                         hit_o
);

  localparam int unsigned W = COORD_BITS;

  // The block is fully pipelined, so it never pushes back on commands.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Axis stage: the subtractions and per-axis tests run ahead of the first
  // register, so that register holds fractions rather than raw coordinates.
  logic signed [W:0]    en_nx_d, ex_nx_d, en_ny_d, ex_ny_d;
  logic        [W-1:0]  den_x_d, den_y_d;
  sbi_pkg::axis_flags_t flags_x_d, flags_y_d;

  sbi_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .start_i (start_x_i),
    .end_i   (end_x_i),
    .lo_i    (box_min_x_i),
    .hi_i    (box_max_x_i),
    .en_n_o  (en_nx_d),
    .ex_n_o  (ex_nx_d),
    .den_o   (den_x_d),
    .flags_o (flags_x_d)
  );

  sbi_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .start_i (start_y_i),
    .end_i   (end_y_i),
    .lo_i    (box_min_y_i),
    .hi_i    (box_max_y_i),
    .en_n_o  (en_ny_d),
    .ex_n_o  (ex_ny_d),
    .den_o   (den_y_d),
    .flags_o (flags_y_d)
  );

  // Input register. Only the valid bit is reset; payload follows accept.
  logic                 valid_q;
  logic signed [W:0]    en_nx_q, ex_nx_q, en_ny_q, ex_ny_q;
  logic        [W-1:0]  den_x_q, den_y_q;
  sbi_pkg::axis_flags_t flags_x_q, flags_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      en_nx_q   <= en_nx_d;
      ex_nx_q   <= ex_nx_d;
      den_x_q   <= den_x_d;
      flags_x_q <= flags_x_d;
      en_ny_q   <= en_ny_d;
      ex_ny_q   <= ex_ny_d;
      den_y_q   <= den_y_d;
      flags_y_q <= flags_y_d;
    end
  end

  // Result stage: cross-axis multiply and compare.
  logic hit_d;

  sbi_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .en_nx_i   (en_nx_q),
    .ex_nx_i   (ex_nx_q),
    .den_x_i   (den_x_q),
    .en_ny_i   (en_ny_q),
    .ex_ny_i   (ex_ny_q),
    .den_y_i   (den_y_q),
    .flags_x_i (flags_x_q),
    .flags_y_i (flags_y_q),
    .hit_o     (hit_d)
  );

  // Result register. The verdict is gated by the strobe so hit_o reads
  // zero whenever no result is on the port.
  logic done_q, hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      hit_q <= hit_d;
    end
  end

  assign done_o = done_q;
  assign hit_o  = done_q && hit_q;

endmodule

// ----- sv/sbi_axis.sv -----
// ----------------------------------------------------------------------------
// sbi_axis
// Builds the entry and exit fractions of one axis and its local tests.
// ----------------------------------------------------------------------------
module sbi_axis #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0] start_i,
  input  logic signed [COORD_BITS-1:0] end_i,
  input  logic signed [COORD_BITS-1:0] lo_i,
  input  logic signed [COORD_BITS-1:0] hi_i,
  output logic signed [COORD_BITS:0]   en_n_o,
  output logic signed [COORD_BITS:0]   ex_n_o,
  output logic        [COORD_BITS-1:0] den_o,
  output sbi_pkg::axis_flags_t         flags_o
);

  localparam int unsigned W = COORD_BITS;

  logic signed [W:0] s_ext, e_ext, lo_ext, hi_ext;
  logic signed [W:0] d, d_neg;
  logic              d_zero, d_pos;

  assign s_ext  = {start_i[W-1], start_i};
  assign e_ext  = {end_i[W-1], end_i};
  assign lo_ext = {lo_i[W-1], lo_i};
  assign hi_ext = {hi_i[W-1], hi_i};

  assign d      = e_ext - s_ext;
  assign d_neg  = s_ext - e_ext;
  assign d_zero = (d == '0);
  assign d_pos  = !d[W] && !d_zero;

  // Moving toward negative coordinates swaps the roles of the two faces.
  assign en_n_o = d_pos ? (lo_ext - s_ext) : (s_ext - hi_ext);
  assign ex_n_o = d_pos ? (hi_ext - s_ext) : (s_ext - lo_ext);
  assign den_o  = d_pos ? d[W-1:0] : d_neg[W-1:0];

  always_comb begin
    flags_o.active = !d_zero;
    if (d_zero) begin
      flags_o.ok = (s_ext >= lo_ext) && (s_ext <= hi_ext);
    end else begin
      flags_o.ok = !ex_n_o[W]
                && (en_n_o <= $signed({1'b0, den_o}))
                && (en_n_o <= ex_n_o);
    end
  end

endmodule

// ----- sv/sbi_cross.sv -----
// ----------------------------------------------------------------------------
// sbi_cross
// Compares the entry of each axis against the exit of the other axis.
// ----------------------------------------------------------------------------
module sbi_cross #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic signed [COORD_BITS:0]   en_nx_i,
  input  logic signed [COORD_BITS:0]   ex_nx_i,
  input  logic        [COORD_BITS-1:0] den_x_i,
  input  logic signed [COORD_BITS:0]   en_ny_i,
  input  logic signed [COORD_BITS:0]   ex_ny_i,
  input  logic        [COORD_BITS-1:0] den_y_i,
  input  sbi_pkg::axis_flags_t         flags_x_i,
  input  sbi_pkg::axis_flags_t         flags_y_i,
  output logic                         hit_o
);

  localparam int unsigned W = COORD_BITS;
  localparam int unsigned PW = 2 * W + 2;

  logic signed [W:0]    dx_s, dy_s;
  logic signed [PW-1:0] p_enx, p_exy, p_eny, p_exx;
  logic                 cross_ok;

  assign dx_s = $signed({1'b0, den_x_i});
  assign dy_s = $signed({1'b0, den_y_i});

  // Denominators are positive, so cross products keep the order of fractions.
  assign p_enx = PW'(en_nx_i) * PW'(dy_s);
  assign p_exy = PW'(ex_ny_i) * PW'(dx_s);
  assign p_eny = PW'(en_ny_i) * PW'(dx_s);
  assign p_exx = PW'(ex_nx_i) * PW'(dy_s);

  assign cross_ok = !(flags_x_i.active && flags_y_i.active)
                 || ((p_enx <= p_exy) && (p_eny <= p_exx));

  assign hit_o = flags_x_i.ok && flags_y_i.ok && cross_ok;

endmodule

// ----- sv/sbi_checker.sv -----
// ----------------------------------------------------------------------------
// sbi_checker
// Port-level checks of the segment versus box intersection block.
// ----------------------------------------------------------------------------
module sbi_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic hit_o
);

  // The pipeline never refuses a command.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy rose although the block accepts every cycle");

  // Every accepted command yields a result strobe.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("accepted command produced no result on time");

  // No result appears without a matching command accepted before it.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, sbi_pkg::ResultLatency))
    else $error("result strobe without a matching command");

  // A hit is only ever reported alongside the strobe.
  a_hit_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> done_o)
    else $error("hit raised outside a result beat");

endmodule

bind segment_box_intersect_2d sbi_checker u_sbi_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .hit_o  (hit_o)
);

// ----- sim/tb_segment_box_intersect_2d.sv -----
// ----------------------------------------------------------------------------
// tb_segment_box_intersect_2d
// Self-checking testbench for the exact 2D segment versus box slab test.
// ----------------------------------------------------------------------------
// A short table of hand-picked segments and boxes runs first. Rows whose
// verdict is obvious carry it typed in. All other rows, and several hundred
// random beats after them, are checked against a slab-test predictor that
// compares the entry and exit fractions by cross-multiplication.
// Command beats are spaced by random idle cycles, except for one long run of
// back-to-back beats. Every done_o strobe is matched in order against the
// oldest outstanding verdict.
// ----------------------------------------------------------------------------
module tb_segment_box_intersect_2d;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned RANDOM_BEATS = 600;
  // Back-to-back window inside the random part, counted in random beats.
  localparam int unsigned BURST_FIRST = 200;
  localparam int unsigned BURST_LAST = 349;
  localparam int unsigned CYCLE_LIMIT = 50000;
  localparam int unsigned IDLE_PERCENT = 36;

  // A directed row either carries its verdict or leaves it to the predictor.
  localparam bit TYPED = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One command beat: the segment and the box it is tested against.
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_max_x;
    coord_t box_max_y;
  } seg_box_t;

  typedef struct {
    bit       typed;
    logic     hit;
    seg_box_t geo;
  } directed_row_t;

  // One outstanding verdict, tagged with the beat number for messages.
  typedef struct {
    int unsigned beat;
    logic        hit;
  } verdict_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  coord_t start_x_i = '0;
  coord_t start_y_i = '0;
  coord_t end_x_i = '0;
  coord_t end_y_i = '0;
  coord_t box_min_x_i = '0;
  coord_t box_min_y_i = '0;
  coord_t box_max_x_i = '0;
  coord_t box_max_y_i = '0;
  logic   done_o;
  logic   hit_o;

  verdict_t      pending_verdicts[$];
  directed_row_t directed_rows[];

  int unsigned beats_sent = 0;
  int unsigned directed_sent = 0;
  int unsigned random_sent = 0;
  int unsigned hits_seen = 0;
  int unsigned misses_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  segment_box_intersect_2d #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .box_min_x_i(box_min_x_i),
    .box_min_y_i(box_min_y_i),
    .box_max_x_i(box_max_x_i),
    .box_max_y_i(box_max_y_i),
    .done_o     (done_o),
    .hit_o      (hit_o)
  );

  always #2 clk_i = ~clk_i;

  // Slab test. Each moving axis contributes an entry and an exit fraction
  // that share one positive denominator; the fixed bounds 0/1 and 1/1 form a
  // third pair. The segment touches the closed box when every entry is at
  // most every exit. Magnitudes stay below 2^18, so the products fit easily
  // in 64 bits and the compare is exact. A stationary axis only asks whether
  // the start lies within the box on that axis. Pairing an axis with itself
  // also rejects an inverted box.
  function automatic logic slab_hit(input seg_box_t c);
    longint p0[2];
    longint lo[2];
    longint hi[2];
    longint num_in[3];
    longint num_out[3];
    longint den[3];
    longint dir;
    int     n;
    int     a;
    int     i;
    int     j;
    logic   touch;
    p0[0] = c.start_x;
    p0[1] = c.start_y;
    lo[0] = c.box_min_x;
    lo[1] = c.box_min_y;
    hi[0] = c.box_max_x;
    hi[1] = c.box_max_y;
    num_in[0] = 0;
    num_out[0] = 1;
    den[0] = 1;
    n = 1;
    touch = 1'b1;
    for (a = 0; a < 2; a++) begin
      dir = (a == 0) ? longint'(c.end_x) - p0[0] : longint'(c.end_y) - p0[1];
      if (dir == 0) begin
        if (p0[a] < lo[a] || p0[a] > hi[a]) touch = 1'b0;
      end else if (dir > 0) begin
        num_in[n] = lo[a] - p0[a];
        num_out[n] = hi[a] - p0[a];
        den[n] = dir;
        n++;
      end else begin
        // Moving toward smaller values: the far face is entered first.
        num_in[n] = p0[a] - hi[a];
        num_out[n] = p0[a] - lo[a];
        den[n] = -dir;
        n++;
      end
    end
    for (i = 0; i < n; i++) begin
      for (j = 0; j < n; j++) begin
        if (num_in[i] * den[j] > num_out[j] * den[i]) touch = 1'b0;
      end
    end
    return touch;
  endfunction

  function automatic seg_box_t geo(input int sx, input int sy, input int ex, input int ey,
                                   input int x0, input int y0, input int x1, input int y1);
    seg_box_t c;
    c.start_x = coord_t'(sx);
    c.start_y = coord_t'(sy);
    c.end_x = coord_t'(ex);
    c.end_y = coord_t'(ey);
    c.box_min_x = coord_t'(x0);
    c.box_min_y = coord_t'(y0);
    c.box_max_x = coord_t'(x1);
    c.box_max_y = coord_t'(y1);
    return c;
  endfunction

  // A coordinate near the origin, stretched by a power of two so that the
  // same shapes also appear at large magnitudes.
  function automatic int near_coord(input int span, input int scale);
    return (int'($urandom_range(0, 2 * span)) - span) * scale;
  endfunction

  // A coordinate biased toward the edges of the signed range.
  function automatic coord_t edge_coord();
    case ($urandom_range(0, 4))
      0: return coord_t'(-32768);
      1: return coord_t'(32767);
      2: return coord_t'(0);
      3: return coord_t'(-1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Most random beats place a small box among nearby segment endpoints, so
  // hits and misses both come often and the faces get real exercise; some
  // of these then get a degenerate segment or an inverted box. The rest are
  // raw random values or values at the edges of the range.
  function automatic seg_box_t random_geo();
    seg_box_t c;
    coord_t   swap;
    int       scale;
    int       x0;
    int       y0;
    int       kind;
    scale = 1 << $urandom_range(0, 9);
    x0 = near_coord(40, 1);
    y0 = near_coord(40, 1);
    c = geo(near_coord(60, scale), near_coord(60, scale),
            near_coord(60, scale), near_coord(60, scale),
            x0 * scale, y0 * scale,
            (x0 + int'($urandom_range(0, 20))) * scale,
            (y0 + int'($urandom_range(0, 20))) * scale);
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: c = seg_box_t'({$urandom, $urandom, $urandom, $urandom});
      6: begin
        // A point: both axes stationary.
        c.end_x = c.start_x;
        c.end_y = c.start_y;
      end
      7: begin
        // Axis-parallel segment: one stationary axis.
        if ($urandom_range(0, 1)) c.end_x = c.start_x;
        else c.end_y = c.start_y;
      end
      8: begin
        if ($urandom_range(0, 1)) begin
          swap = c.box_min_x;
          c.box_min_x = c.box_max_x;
          c.box_max_x = swap;
        end else begin
          swap = c.box_min_y;
          c.box_min_y = c.box_max_y;
          c.box_max_y = swap;
        end
      end
      9: c = {edge_coord(), edge_coord(), edge_coord(), edge_coord(),
              edge_coord(), edge_coord(), edge_coord(), edge_coord()};
      default: ;
    endcase
    return c;
  endfunction

  // Called in the step right after a rising edge. Drives one command beat,
  // after some idle cycles when allowed, and returns in the step of the edge
  // that accepts it with its verdict queued. Start is assigned exactly once
  // per step, so a beat that follows directly keeps start high throughout.
  task automatic issue_beat(input seg_box_t c, input bit typed, input logic typed_hit,
                            input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    start_x_i <= c.start_x;
    start_y_i <= c.start_y;
    end_x_i <= c.end_x;
    end_y_i <= c.end_y;
    box_min_x_i <= c.box_min_x;
    box_min_y_i <= c.box_min_y;
    box_max_x_i <= c.box_max_x;
    box_max_y_i <= c.box_max_y;
    // Busy is read as it stood before the edge, just as the block sees it.
    do @(posedge clk_i); while (busy);
    pending_verdicts.push_back('{beat: beats_sent, hit: typed ? typed_hit : slab_hit(c)});
    beats_sent++;
  endtask

  // The receiver cannot stall, so every strobe is a result beat that must
  // match the oldest outstanding verdict.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no command outstanding: hit=%0b", hit_o);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (hit_o !== want.hit) begin
          $error("beat %0d: field hit: expected %0b, actual %0b", want.beat, want.hit, hit_o);
          error_count++;
        end
        if (hit_o === 1'b1) hits_seen++;
        else misses_seen++;
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d results outstanding",
               cycle_count, pending_verdicts.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned idx;
    int unsigned drain;

    // Box (0,0)-(10,10) unless a row says otherwise.
    directed_rows = '{
      // Point-in-box tests from zero-length segments.
      '{TYPED, 1'b1, geo(5, 5, 5, 5, 0, 0, 10, 10)},
      '{TYPED, 1'b0, geo(20, 5, 20, 5, 0, 0, 10, 10)},
      // Inverted boxes reject even a segment through the middle.
      '{TYPED, 1'b0, geo(-5, 5, 15, 5, 10, 0, 0, 10)},
      '{TYPED, 1'b0, geo(5, -5, 5, 15, 0, 10, 10, 0)},
      '{TYPED, 1'b0, geo(-32768, 32767, -32768, 32767, 32767, -32768, -32768, 32767)},
      // Grazing the top face, touching a corner and touching a side face count as hits.
      '{TYPED, 1'b1, geo(-5, 10, 5, 10, 0, 0, 10, 10)},
      '{TYPED, 1'b1, geo(-10, -10, 0, 0, 0, 0, 10, 10)},
      '{TYPED, 1'b1, geo(-10, 5, 0, 5, 0, 0, 10, 10)},
      '{TYPED, 1'b1, geo(10, 5, 20, 5, 0, 0, 10, 10)},
      // Plain crossings and misses along one axis.
      '{TYPED, 1'b0, geo(-100, 5, -50, 5, 0, 0, 10, 10)},
      '{TYPED, 1'b1, geo(-100, 5, 100, 5, 0, 0, 10, 10)},
      '{TYPED, 1'b1, geo(5, -100, 5, 100, 0, 0, 10, 10)},
      '{TYPED, 1'b0, geo(20, -100, 20, 100, 0, 0, 10, 10)},
      // Extremes of the coordinate range.
      '{TYPED, 1'b1, geo(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767)},
      '{TYPED, 1'b1, geo(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767)},
      '{TYPED, 1'b1, geo(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767)},
      '{TYPED, 1'b1, geo(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768)},
      // Verdicts that need the fractions worked out.
      '{PREDICTED, 1'b0, geo(-10, 0, 0, -10, 0, 0, 10, 10)},
      '{PREDICTED, 1'b0, geo(32767, 32767, -32768, -32768, 0, 0, 0, 0)},
      '{PREDICTED, 1'b0, geo(32767, -32768, -32768, 32767, -1, -1, 1, 1)},
      '{PREDICTED, 1'b0, geo(-32768, 0, 32767, 1, 0, 0, 32767, 0)},
      '{PREDICTED, 1'b0, geo(3, 3, 30000, -30000, 0, 0, 10, 10)}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      issue_beat(directed_rows[r].geo, directed_rows[r].typed, directed_rows[r].hit, 1'b1);
      directed_sent++;
    end

    for (idx = 0; idx < RANDOM_BEATS; idx++) begin
      issue_beat(random_geo(), PREDICTED, 1'b0,
                 !(idx >= BURST_FIRST && idx <= BURST_LAST));
      random_sent++;
    end
    start <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    // Linger past the pipeline depth so a stray extra strobe is caught.
    for (drain = 0; drain < sbi_pkg::ResultLatency + 8; drain++) @(posedge clk_i);

    $display("Ran %0d table rows and %0d random segment/box beats in %0d cycles.",
             directed_sent, random_sent, cycle_count);
    $display("Results seen: %0d hits and %0d misses; %0d errors.",
             hits_seen, misses_seen, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
